// ===== src/spt_pkg.sv =====
// Shared types and constants for the salience/priority context table.
// No dependencies.
`timescale 1ns / 1ps
package spt_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int KEY_BITS    = 16;
  localparam int TIME_BITS   = 48;
  localparam int MUL_W       = 20;

  localparam logic [2:0] REQ_INGEST    = 3'd0;
  localparam logic [2:0] REQ_REINFORCE = 3'd1;
  localparam logic [2:0] REQ_SUPPRESS  = 3'd2;
  localparam logic [2:0] REQ_FOCUS     = 3'd3;
  localparam logic [2:0] REQ_GET       = 3'd4;
  localparam logic [2:0] REQ_CLEAR     = 3'd5;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  localparam logic [15:0] ONE_Q15 = 16'd32768;

  // floor(x/10) = (x * RECIP10) >> 23, floor(x/5) = (x * RECIP5) >> 20
  localparam logic [MUL_W-1:0] RECIP10 = 20'd838861;
  localparam logic [MUL_W-1:0] RECIP5  = 20'd209716;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] key_id;
    logic [15:0] salience_in;
    logic [15:0] urgency_in;
    logic [15:0] amount;
    logic [47:0] timestamp;
    logic [4:0]  focus_limit;
  } req_t;

  typedef struct packed {
    logic [15:0] out_key;
    logic [15:0] out_salience;
    logic [15:0] out_priority;
    logic [47:0] out_seen_time;
    logic [15:0] out_observations;
    logic        focused;
    logic [1:0]  status;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [15:0]          sal;
    logic [15:0]          pri;
    logic [TIME_BITS-1:0] seen;
    logic [15:0]          obs;
  } entry_t;

  typedef struct packed {
    logic                 clr;
    logic                 we;
    logic [IDX_W-1:0]     widx;
    logic [IDX_W-1:0]     ridx;
  } store_ctl_t;

endpackage

// ===== src/spt_store.sv =====
// Entry storage: valid flags plus per-slot key, scores, time and count.
// Depends on spt_pkg.
`timescale 1ns / 1ps
module spt_store (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  spt_pkg::store_ctl_t                 ctl_i,
  input  spt_pkg::entry_t                     wdata_i,
  output spt_pkg::entry_t                     rdata_o,
  output logic [spt_pkg::NUM_ENTRIES-1:0]     valid_o
);
  import spt_pkg::*;

  entry_t                 mem_q [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.clr) begin
      valid_q <= '0;
    end else if (ctl_i.we) begin
      valid_q[ctl_i.widx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[ctl_i.widx] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[ctl_i.ridx];
  assign valid_o = valid_q;

endmodule

// ===== src/spt_mul.sv =====
// Shared registered multiplier used by the update sequencer.
// Depends on spt_pkg.
`timescale 1ns / 1ps
module spt_mul (
  input  logic                          clk_i,
  input  logic [spt_pkg::MUL_W-1:0]     a_i,
  input  logic [spt_pkg::MUL_W-1:0]     b_i,
  output logic [2*spt_pkg::MUL_W-1:0]   p_o
);
  import spt_pkg::*;

  logic [2*MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (2*MUL_W)'(a_i) * (2*MUL_W)'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== src/salience_priority_table_top.sv =====
// Salience/priority context table, top level: sequencer and output register.
// Depends on spt_pkg, spt_store, spt_mul.
`timescale 1ns / 1ps
// One request word is taken at a time; in_ready_o stays low until the last
// result word of the request has been taken. Clear, empty-key requests and
// focus with nothing to list answer in the cycle after acceptance. Ingest,
// reinforce, suppress and get first scan the table one slot per cycle, then
// run 2 (ingest), 3 (reinforce) or 5 (suppress) steps on the single shared
// multiplier before write-back; get answers right after the scan. Focus
// ranks by a full scan per emitted word; an output stall holds each word
// until it is taken. Scores are Q1.15 and saturate at 1.0.
module salience_priority_table_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spt_pkg::req_t   in_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output spt_pkg::rsp_t   out_o,
  output logic            out_valid_o,
  input  logic            out_ready_i
);
  import spt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FIND, ST_DECIDE, ST_CALC0, ST_CALC1, ST_CALC2, ST_CALC3,
    ST_CALC4, ST_WB, ST_FSCAN, ST_FEMIT
  } state_e;

  state_e                 state_q;
  req_t                   req_q;
  logic [IDX_W-1:0]       idx_q, hit_idx_q, free_idx_q, slot_q, best_idx_q;
  logic                   hit_q, free_found_q, alloc_q, best_found_q;
  logic [15:0]            sal_q, pri_q;
  logic [NUM_ENTRIES-1:0] taken_q;
  logic [CNT_W-1:0]       vcnt_q;
  logic [4:0]             n_q, total_q;
  logic [16:0]            best_sum_q;
  entry_t                 best_ent_q;
  rsp_t                   out_q;
  logic                   out_valid_q;

  store_ctl_t             sctl;
  entry_t                 wdata, rdata;
  logic [NUM_ENTRIES-1:0] valid;
  logic [MUL_W-1:0]       mul_a, mul_b;
  logic [2*MUL_W-1:0]     prod;
  logic [2*MUL_W-1:0]     rnd_p, rnd_s;
  logic [16:0]            cur_sum;
  logic                   last_idx, key_match;

  spt_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (sctl),
    .wdata_i (wdata),
    .rdata_o (rdata),
    .valid_o (valid)
  );

  spt_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  function automatic logic [15:0] sat_in(input logic [15:0] v);
    return (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

  function automatic logic [15:0] sat_sum(input logic [16:0] v);
    return (v > 17'(ONE_Q15)) ? ONE_Q15 : v[15:0];
  endfunction

  function automatic rsp_t mk_rsp(input entry_t e, input logic use_e, input logic foc,
                                  input logic [1:0] st, input logic lst);
    rsp_t r;
    r.out_key          = use_e ? 16'(e.key) : '0;
    r.out_salience     = use_e ? e.sal : '0;
    r.out_priority     = use_e ? e.pri : '0;
    r.out_seen_time    = use_e ? 48'(e.seen) : '0;
    r.out_observations = use_e ? e.obs : '0;
    r.focused          = foc;
    r.status           = st;
    r.last             = lst;
    return r;
  endfunction

  assign in_ready_o  = (state_q == ST_IDLE) && !out_valid_q;
  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  assign last_idx  = (idx_q == IDX_W'(NUM_ENTRIES - 1));
  assign key_match = (rdata.key == req_q.key_id[KEY_BITS-1:0]);
  assign cur_sum   = 17'(rdata.sal) + 17'(rdata.pri);
  assign rnd_p     = prod + 40'd81920;
  assign rnd_s     = prod + 40'd163840;

  // store control and write data
  always_comb begin
    sctl.clr  = in_valid_i && in_ready_o && (in_i.req_type == REQ_CLEAR);
    sctl.we   = (state_q == ST_WB);
    sctl.widx = slot_q;
    unique case (state_q) inside
      ST_FIND, ST_FSCAN: sctl.ridx = idx_q;
      ST_DECIDE:         sctl.ridx = hit_idx_q;
      default:           sctl.ridx = slot_q;
    endcase
    wdata.key  = req_q.key_id[KEY_BITS-1:0];
    wdata.sal  = sal_q;
    wdata.pri  = pri_q;
    wdata.seen = rdata.seen;
    wdata.obs  = alloc_q ? 16'd0 : rdata.obs;
    if (req_q.req_type == REQ_INGEST) begin
      wdata.seen = req_q.timestamp[TIME_BITS-1:0];
      if (wdata.obs != 16'hFFFF) begin
        wdata.obs = wdata.obs + 16'd1;
      end
    end
  end

  // multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_CALC0: begin
        unique case (req_q.req_type)
          REQ_INGEST: begin
            mul_a = MUL_W'(sal_q) * 20'd7 + MUL_W'(req_q.salience_in) * 20'd3 + 20'd5;
            mul_b = RECIP10;
          end
          REQ_REINFORCE: begin
            mul_a = MUL_W'(req_q.amount) * 20'd2 + 20'd5;
            mul_b = RECIP10;
          end
          default: begin
            mul_a = MUL_W'(pri_q);
            mul_b = 20'd163840 - MUL_W'(req_q.amount);
          end
        endcase
      end
      ST_CALC1: begin
        if (req_q.req_type == REQ_REINFORCE) begin
          mul_a = MUL_W'(req_q.amount) + 20'd5;
          mul_b = RECIP10;
        end else begin
          mul_a = rnd_p[34:15];
          mul_b = RECIP5;
        end
      end
      ST_CALC2: begin
        mul_a = MUL_W'(sal_q);
        mul_b = 20'd327680 - MUL_W'(req_q.amount);
      end
      ST_CALC3: begin
        mul_a = rnd_s[34:15];
        mul_b = RECIP10;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      req_q        <= '0;
      idx_q        <= '0;
      hit_idx_q    <= '0;
      free_idx_q   <= '0;
      slot_q       <= '0;
      best_idx_q   <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      alloc_q      <= 1'b0;
      best_found_q <= 1'b0;
      sal_q        <= '0;
      pri_q        <= '0;
      taken_q      <= '0;
      vcnt_q       <= '0;
      n_q          <= '0;
      total_q      <= '0;
      best_sum_q   <= '0;
      best_ent_q   <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_FEMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            req_q        <= {in_i.req_type, in_i.key_id, sat_in(in_i.salience_in),
                             sat_in(in_i.urgency_in), sat_in(in_i.amount),
                             in_i.timestamp, in_i.focus_limit};
            idx_q        <= '0;
            hit_q        <= 1'b0;
            free_found_q <= 1'b0;
            alloc_q      <= 1'b0;
            best_found_q <= 1'b0;
            taken_q      <= '0;
            n_q          <= '0;
            unique case (in_i.req_type) inside
              REQ_CLEAR: begin
                vcnt_q      <= '0;
                out_q       <= mk_rsp('0, 1'b0, 1'b0, STAT_OK, 1'b1);
                out_valid_q <= 1'b1;
              end
              REQ_FOCUS: begin
                if (in_i.focus_limit == 5'd0 || vcnt_q == '0) begin
                  out_q       <= mk_rsp('0, 1'b0, 1'b1, STAT_NOTFOUND, 1'b1);
                  out_valid_q <= 1'b1;
                end else begin
                  total_q <= (in_i.focus_limit < 5'(vcnt_q)) ? in_i.focus_limit
                                                             : 5'(vcnt_q);
                  state_q <= ST_FSCAN;
                end
              end
              REQ_INGEST, REQ_REINFORCE, REQ_SUPPRESS, REQ_GET: begin
                if (in_i.key_id[KEY_BITS-1:0] == '0) begin
                  out_q       <= mk_rsp('0, 1'b0, 1'b0, STAT_EMPTY, 1'b1);
                  out_valid_q <= 1'b1;
                end else begin
                  state_q <= ST_FIND;
                end
              end
              default: ;
            endcase
          end
        end
        ST_FIND: begin
          if (valid[idx_q] && key_match && !hit_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= idx_q;
          end
          if (!valid[idx_q] && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= idx_q;
          end
          idx_q <= idx_q + 1'b1;
          if (last_idx) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (hit_q) begin
            slot_q <= hit_idx_q;
            sal_q  <= rdata.sal;
            pri_q  <= rdata.pri;
            if (req_q.req_type == REQ_GET) begin
              out_q       <= mk_rsp(rdata, 1'b1, 1'b0, STAT_OK, 1'b1);
              out_valid_q <= 1'b1;
              state_q     <= ST_IDLE;
            end else begin
              state_q <= ST_CALC0;
            end
          end else if (req_q.req_type == REQ_INGEST && free_found_q) begin
            slot_q  <= free_idx_q;
            alloc_q <= 1'b1;
            sal_q   <= '0;
            pri_q   <= '0;
            vcnt_q  <= vcnt_q + 1'b1;
            state_q <= ST_CALC0;
          end else begin
            out_q       <= mk_rsp('0, 1'b0, 1'b0,
                                  (req_q.req_type == REQ_INGEST) ? STAT_FULL
                                                                 : STAT_NOTFOUND,
                                  1'b1);
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        ST_CALC0: state_q <= ST_CALC1;
        ST_CALC1: begin
          unique case (req_q.req_type)
            REQ_INGEST: begin
              sal_q   <= sat_sum({1'b0, prod[38:23]});
              pri_q   <= sat_sum(17'((19'(pri_q) * 19'd2 + 19'(req_q.salience_in)
                                      + 19'(req_q.urgency_in) + 19'd2) >> 2));
              state_q <= ST_WB;
            end
            REQ_REINFORCE: begin
              pri_q   <= sat_sum(17'(pri_q) + 17'(prod[38:23]));
              state_q <= ST_CALC2;
            end
            default: state_q <= ST_CALC2;
          endcase
        end
        ST_CALC2: begin
          if (req_q.req_type == REQ_REINFORCE) begin
            sal_q   <= sat_sum(17'(sal_q) + 17'(prod[38:23]));
            state_q <= ST_WB;
          end else begin
            pri_q   <= sat_sum({1'b0, prod[35:20]});
            state_q <= ST_CALC3;
          end
        end
        ST_CALC3: state_q <= ST_CALC4;
        ST_CALC4: begin
          sal_q   <= sat_sum({1'b0, prod[38:23]});
          state_q <= ST_WB;
        end
        ST_WB: begin
          out_q       <= mk_rsp(wdata, 1'b1, 1'b0, STAT_OK, 1'b1);
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        ST_FSCAN: begin
          if (valid[idx_q] && !taken_q[idx_q] &&
              (!best_found_q || cur_sum > best_sum_q)) begin
            best_found_q <= 1'b1;
            best_sum_q   <= cur_sum;
            best_idx_q   <= idx_q;
            best_ent_q   <= rdata;
          end
          idx_q <= idx_q + 1'b1;
          if (last_idx) begin
            state_q <= ST_FEMIT;
          end
        end
        ST_FEMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= mk_rsp(best_ent_q, 1'b1, 1'b1, STAT_OK,
                                  (n_q + 5'd1 == total_q));
            out_valid_q <= 1'b1;
            taken_q[best_idx_q] <= 1'b1;
            n_q          <= n_q + 5'd1;
            best_found_q <= 1'b0;
            idx_q        <= '0;
            state_q      <= (n_q + 5'd1 == total_q) ? ST_IDLE : ST_FSCAN;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
